FILE: rtl/rmsd_pkg.sv
`timescale 1ns / 1ps
// rmsd_pkg: widths, limits and the result record shared by the rmsd modules
// no dependencies

package rmsd_pkg;

    // squared distance sum, Q.20, saturating
    localparam int SUM_W = 60;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // integer square root of the mean
    localparam int ROOT_W = SUM_W / 2;

    // result fields
    localparam int DEV_W  = 22;
    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};
    localparam int PCNT_W = 13;
    localparam int RES_W  = DEV_W + PCNT_W + 1;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic                count_overflow;
        logic [PCNT_W-1:0]   pair_count;
        logic [DEV_W-1:0]    deviation;
    } result_t;

endpackage

FILE: rtl/coordinate_rmsd_accumulator.sv
`timescale 1ns / 1ps
// coordinate_rmsd_accumulator: top level, stream ports around front end, queue and back end
// depends on rmsd_pkg, rmsd_front, rmsd_queue, rmsd_back
//
// usage:
//   s_ channel: one word per matched atom pair, six signed coordinates in s_tdata,
//   s_tlast marks the final pair of a set. m_ channel: one word per set with the
//   rms deviation, the pair count and the overflow flag.
//   the front end takes one word per cycle, unless a last word waits on a full queue,
//   through three register stages and adds each squared distance into the running
//   sum; the set closed by s_tlast goes into a two-entry queue and the sum and count clear.
//   the back end runs a bit-serial division and then a bit-serial square root, and
//   takes the next set from the queue only once the result of the last set has
//   been taken.
//   s_tready drops only while a last word meets a full queue; short sets faster than
//   the back end fill the queue and then stall the input.
//   a stalled receiver holds the result in the output register; the back end waits,
//   the queue and then the input back up behind it.
//   reset (aresetn low, synchronous) clears the sum, count, queue and both pipelines.

module coordinate_rmsd_accumulator import rmsd_pkg::*; #(
    parameter int MAX_PAIRS  = 4096,
    parameter int COORD_BITS = 22
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // deviation, pair_count, count_overflow, zero fill
    output logic [M_TDATA_W-1:0]                   m_tdata
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int Q_W   = SUM_W + CNT_W + 1;

    logic           push, q_full, q_empty, q_pop;
    logic [Q_W-1:0] push_data, pop_data;
    result_t        res;

    rmsd_front #(
        .MAX_PAIRS  (MAX_PAIRS),
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_coords (s_tdata[6*COORD_BITS-1:0]),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rmsd_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    rmsd_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = M_TDATA_W'({res.count_overflow, res.pair_count, res.deviation});

endmodule

FILE: rtl/rmsd_front.sv
`timescale 1ns / 1ps
// rmsd_front: takes coordinate pairs, squares the differences and keeps the running sum
// depends on rmsd_pkg; hands each finished set to the queue

module rmsd_front import rmsd_pkg::*; #(
    parameter int MAX_PAIRS  = 4096,
    parameter int COORD_BITS = 22,
    parameter int CNT_W      = 13
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [6*COORD_BITS-1:0]    in_coords,
    input  logic                       in_last,
    input  logic                       q_full,
    output logic                       push,
    output logic [SUM_W+CNT_W:0]       push_data
);

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int EXT_W = (SQ_W > SUM_W) ? SQ_W : SUM_W;

    logic              v1_reg, v2_reg, v3_reg;
    logic              last1_reg, last2_reg, last3_reg;
    logic [C-1:0]      abs1_reg [3];
    logic [SUM_W-1:0]  sq2_reg [3];
    logic [SUM_W-1:0]  d2_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;

    logic signed [C:0] diff [3];
    logic [C:0]        mag [3];
    logic [C-1:0]      abs1_next [3];
    logic [SQ_W-1:0]   prod [3];
    logic [EXT_W-1:0]  prod_ext [3];
    logic [SUM_W-1:0]  sq2_next [3];
    logic [SUM_W+1:0]  sum3;
    logic [SUM_W-1:0]  d2_next;
    logic [SUM_W:0]    acc;
    logic              adv, take, cnt_full;

    // a last word waits in the final stage while the queue is full
    assign adv      = !(v3_reg && last3_reg && q_full);
    assign in_ready = adv;
    assign take     = v3_reg && adv;
    assign push     = take && last3_reg;

    // stage one: absolute differences per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = $signed({in_coords[i*C+C-1], in_coords[i*C +: C]})
                    - $signed({in_coords[(i+3)*C+C-1], in_coords[(i+3)*C +: C]});
            mag[i] = diff[i][C] ? (C+1)'(-diff[i]) : diff[i];
            abs1_next[i] = mag[i][C-1:0];
        end
    end

    // stage two: squares, saturated to the sum width
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i]     = abs1_reg[i] * abs1_reg[i];
            prod_ext[i] = EXT_W'(prod[i]);
            sq2_next[i] = (prod_ext[i] > EXT_W'(SUM_MAX)) ? SUM_MAX
                                                          : SUM_W'(prod_ext[i]);
        end
    end

    // stage three: squared distance of the pair
    always_comb begin
        sum3 = (SUM_W+2)'(sq2_reg[0]) + (SUM_W+2)'(sq2_reg[1]) + (SUM_W+2)'(sq2_reg[2]);
        d2_next = (|sum3[SUM_W+1:SUM_W]) ? SUM_MAX : sum3[SUM_W-1:0];
    end

    // accumulate, or drop the pair once the count is full
    always_comb begin
        acc      = {1'b0, sum_reg} + {1'b0, d2_reg};
        cnt_full = (cnt_reg == CNT_W'(MAX_PAIRS));
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (cnt_full) begin
            ovf_next = 1'b1;
        end else begin
            sum_next = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign push_data = {sum_next, cnt_next, ovf_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (take) begin
                if (last3_reg) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last1_reg <= in_last;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
            abs1_reg  <= abs1_next;
            sq2_reg   <= sq2_next;
            d2_reg    <= d2_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PAIRS))
        else $error("pair count beyond limit");
`endif

endmodule

FILE: rtl/rmsd_queue.sv
`timescale 1ns / 1ps
// rmsd_queue: short queue of finished sets between the front and the back end
// no dependencies

module rmsd_queue #(
    parameter int WIDTH = 78,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;

    assign full     = (level_reg == LVL_W'(DEPTH));
    assign empty    = (level_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/rmsd_back.sv
`timescale 1ns / 1ps
// rmsd_back: mean by restoring division, then integer square root, one bit pair a step
// depends on rmsd_pkg; drives the result register

module rmsd_back import rmsd_pkg::*; #(
    parameter int CNT_W = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  logic [SUM_W+CNT_W:0] q_data,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SR_W       = ROOT_W + 2;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_OUT} state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  work_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              ovf_reg;
    logic [SR_W-1:0]   sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    result_t           res_reg;

    logic [CNT_W:0]    rem_sh, div_diff;
    logic              div_ge;
    logic [CNT_W-1:0]  rem_next;
    logic [SUM_W-1:0]  quo_next;
    logic [SR_W+1:0]   sr_sh, sr_diff;
    logic              sr_ge;
    logic [SR_W-1:0]   sq_rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [DEV_W-1:0]  dev_next;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    // one quotient bit per step
    always_comb begin
        rem_sh   = {rem_reg, work_reg[SUM_W-1]};
        div_diff = rem_sh - {1'b0, div_reg};
        div_ge   = (rem_sh >= {1'b0, div_reg});
        rem_next = div_ge ? div_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_next = {work_reg[SUM_W-2:0], div_ge};
    end

    // one root bit per step, two radicand bits taken in
    always_comb begin
        sr_sh       = {sq_rem_reg, work_reg[SUM_W-1:SUM_W-2]};
        sr_diff     = sr_sh - (SR_W+2)'({root_reg, 2'b01});
        sr_ge       = (sr_sh >= (SR_W+2)'({root_reg, 2'b01}));
        sq_rem_next = sr_ge ? sr_diff[SR_W-1:0] : sr_sh[SR_W-1:0];
        root_next   = {root_reg[ROOT_W-2:0], sr_ge};
        dev_next    = (|root_next[ROOT_W-1:DEV_W]) ? DEV_MAX : root_next[DEV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        work_reg  <= q_data[SUM_W+CNT_W:CNT_W+1];
                        div_reg   <= q_data[CNT_W:1];
                        ovf_reg   <= q_data[0];
                        rem_reg   <= '0;
                        step_reg  <= STEP_W'(DIV_STEPS - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_next;
                    work_reg <= quo_next;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        // an empty set gives a zero mean
                        work_reg   <= (div_reg == '0) ? '0 : quo_next;
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        step_reg   <= STEP_W'(SQRT_STEPS - 1);
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    sq_rem_reg <= sq_rem_next;
                    root_reg   <= root_next;
                    work_reg   <= {work_reg[SUM_W-3:0], 2'b00};
                    step_reg   <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        res_reg.deviation      <= dev_next;
                        res_reg.pair_count     <= PCNT_W'(div_reg);
                        res_reg.count_overflow <= ovf_reg;
                        state_reg              <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_DIV))
        else $error("queue pop did not start a division");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("result changed before it was taken");
`endif

endmodule

FILE: dv/tb_coordinate_rmsd_accumulator.sv
`timescale 1ns / 1ps
// tb_coordinate_rmsd_accumulator: self-checking bench for the rms deviation accumulator
// depends on rmsd_pkg and coordinate_rmsd_accumulator; sets of atom pairs go in with
// random gaps, each returned word is checked against a scoreboard that mirrors the set maths

module tb_coordinate_rmsd_accumulator import rmsd_pkg::*;;

    localparam int MAX_PAIRS    = 4096;
    localparam int COORD_BITS   = 22;
    localparam int S_TDATA_W    = ((6*COORD_BITS+7)/8)*8;
    localparam int RANDOM_PAIRS = 930;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 250;
    localparam int LONG_HOLD    = 800;

    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // first field in the lowest bits, as on s_tdata
    typedef struct packed {
        logic signed [COORD_BITS-1:0] second_z;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_x;
    } atom_pair_t;

    class rmsd_scoreboard;
        logic [63:0]  running_sum;
        int unsigned  pairs_kept;
        bit           pairs_dropped;
        result_t      due_results[$];
        int unsigned  mismatches;

        function new();
            running_sum   = '0;
            pairs_kept    = 0;
            pairs_dropped = 1'b0;
            mismatches    = 0;
        endfunction

        static function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            if (a > 64'(SUM_MAX) || b > 64'(SUM_MAX) - a)
                return 64'(SUM_MAX);
            return a + b;
        endfunction

        static function logic [63:0] axis_sq(logic signed [COORD_BITS-1:0] a,
                                             logic signed [COORD_BITS-1:0] b);
            longint      d;
            logic [63:0] sq;
            d = longint'(a) - longint'(b);
            if (d < 0)
                d = -d;
            sq = 64'(d) * 64'(d);
            return (sq > 64'(SUM_MAX)) ? 64'(SUM_MAX) : sq;
        endfunction

        // digit-by-digit integer root
        static function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] root;
            logic [63:0] probe;
            root  = '0;
            probe = 64'd1 << 62;
            while (probe > x)
                probe >>= 2;
            while (probe != 0) begin
                if (x >= root + probe) begin
                    x    = x - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe >>= 2;
            end
            return root;
        endfunction

        function void note_pair(atom_pair_t p, bit last);
            logic [63:0] d2;
            logic [63:0] mean;
            logic [63:0] root;
            result_t     r;
            if (pairs_kept >= MAX_PAIRS) begin
                pairs_dropped = 1'b1;
            end else begin
                d2 = sat_add(axis_sq(p.first_x, p.second_x), axis_sq(p.first_y, p.second_y));
                d2 = sat_add(d2, axis_sq(p.first_z, p.second_z));
                running_sum = sat_add(running_sum, d2);
                pairs_kept++;
            end
            if (last) begin
                mean = (pairs_kept != 0) ? running_sum / 64'(pairs_kept) : 64'd0;
                root = int_sqrt(mean);
                r.deviation      = (root > 64'(DEV_MAX)) ? DEV_MAX : root[DEV_W-1:0];
                r.pair_count     = pairs_kept[PCNT_W-1:0];
                r.count_overflow = pairs_dropped;
                due_results = {due_results, r};
                running_sum   = '0;
                pairs_kept    = 0;
                pairs_dropped = 1'b0;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                $error("result word with no set outstanding: %h", got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.deviation !== want.deviation) begin
                $error("deviation: expected %0d, got %0d", want.deviation, got.deviation);
                mismatches++;
            end
            if (got.pair_count !== want.pair_count) begin
                $error("pair_count: expected %0d, got %0d", want.pair_count, got.pair_count);
                mismatches++;
            end
            if (got.count_overflow !== want.count_overflow) begin
                $error("count_overflow: expected %0d, got %0d",
                       want.count_overflow, got.count_overflow);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // deviation, pair_count, count_overflow, zero fill
    logic [M_TDATA_W-1:0]   m_tdata;

    rmsd_scoreboard sb = new();
    int unsigned    results_seen = 0;
    int unsigned    idle_cycles  = 0;
    int             burst_left   = 0;

    always #2 aclk = ~aclk;

    coordinate_rmsd_accumulator #(
        .MAX_PAIRS  (MAX_PAIRS),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // handshakes sampled with the values held before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_pair(atom_pair_t'(s_tdata[6*COORD_BITS-1:0]), s_tlast);
            if (m_tvalid && m_tready) begin
                sb.check_result(result_t'(m_tdata[RES_W-1:0]));
                results_seen <= results_seen + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: stretches of always-ready, coin-flip, periodic and mostly-ready,
    // plus one long hold-off once traffic is under way so the queue backs up
    initial begin : receiver
        int  stretch;
        int  mode;
        int  n;
        bit  held;
        held = 1'b0;
        forever begin
            if (!held && results_seen >= 30) begin
                held = 1'b1;
                for (n = 0; n < LONG_HOLD; n++) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            for (n = 0; n < stretch; n++) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (n % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic atom_pair_t pair_of(logic signed [COORD_BITS-1:0] fx, fy, fz, sx, sy, sz);
        atom_pair_t p;
        p.first_x  = fx;
        p.first_y  = fy;
        p.first_z  = fz;
        p.second_x = sx;
        p.second_y = sy;
        p.second_z = sz;
        return p;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] any_coord(int mode);
        case (mode)
            0: return COORD_BITS'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return CMIN;
                    1: return CMAX;
                    2: return '0;
                    3: return '1;
                    default: return COORD_BITS'(1);
                endcase
            end
            default: return COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] nudge();
        return COORD_BITS'(int'($urandom_range(0, 128)) - 64);
    endfunction

    function automatic atom_pair_t random_pair();
        atom_pair_t p;
        int         mode;
        int         sel;
        sel  = $urandom_range(0, 9);
        mode = (sel < 5) ? 0 : (sel < 7) ? 1 : 2;
        p.first_x = any_coord(mode);
        p.first_y = any_coord(mode);
        p.first_z = any_coord(mode);
        if (sel < 4 || sel == 9) begin
            // matched structures: the second point sits close to the first
            p.second_x = p.first_x + nudge();
            p.second_y = p.first_y + nudge();
            p.second_z = p.first_z + nudge();
        end else begin
            p.second_x = any_coord(mode);
            p.second_y = any_coord(mode);
            p.second_z = any_coord(mode);
        end
        return p;
    endfunction

    // called just after an edge; returns once the word has been taken
    task automatic send_pair(atom_pair_t p, bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(p);
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        int left;
        int set_len;
        int k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // single-pair sets: zero, opposite corners, equal corners, one lsb, tiny rounding
        send_pair(pair_of('0, '0, '0, '0, '0, '0), 1'b1);
        send_pair(pair_of(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 1'b1);
        send_pair(pair_of(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN), 1'b1);
        send_pair(pair_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b1);
        send_pair(pair_of(COORD_BITS'(1), '0, '0, '0, '0, '0), 1'b1);
        send_pair(pair_of('1, '1, '1, COORD_BITS'(1), COORD_BITS'(1), COORD_BITS'(1)), 1'b1);
        // root lands exactly on the top code, then just beyond it
        send_pair(pair_of(CMAX, '0, '0, CMIN, '0, '0), 1'b1);
        send_pair(pair_of(CMAX, CMAX, '0, CMIN, CMIN, '0), 1'b1);
        // mean truncates before the root
        send_pair(pair_of('0, '0, '0, COORD_BITS'(3), '0, '0), 1'b0);
        send_pair(pair_of('0, '0, '0, '0, COORD_BITS'(4), '0), 1'b0);
        send_pair(pair_of('0, '0, '0, '0, '0, '0), 1'b1);
        send_pair(pair_of(CMIN, '0, '0, CMAX, '0, '0), 1'b0);
        send_pair(pair_of('0, '0, '0, '0, '0, '0), 1'b1);
        for (k = 1; k <= 4; k++)
            send_pair(random_pair(), k == 4);

        // random sets, mostly short so results are frequent
        left = RANDOM_PAIRS;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: set_len = $urandom_range(1, 4);
                6, 7, 8:          set_len = $urandom_range(5, 20);
                default:          set_len = $urandom_range(21, 60);
            endcase
            if (set_len > left)
                set_len = left;
            for (k = 1; k <= set_len; k++)
                send_pair(random_pair(), k == set_len);
            left -= set_len;
        end

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
